[rtl/accumulator_machine_execute_unit_macros.svh]
// assertion macros shared by the execute unit rtl
`ifndef ACCUMULATOR_MACHINE_EXECUTE_UNIT_MACROS_SVH
`define ACCUMULATOR_MACHINE_EXECUTE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled while reset is low
`define AME_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define AME_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AME_ASSERT_IMP(lbl, ante, cons, msg)
`define AME_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

[rtl/ame_pkg.sv]
// shared types, opcodes and the microcode rom of the accumulator machine
`default_nettype none

package ame_pkg;

    localparam int WORD_BITS     = 16;
    localparam int ADDR_BITS     = 10;
    localparam int OPC_BITS      = 6;
    localparam int CNT_BITS      = $clog2(WORD_BITS);
    localparam int DEF_MEM_DEPTH = 1024;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_EXEC  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    localparam logic [OPC_BITS-1:0] OP_LOAD_MQ  = 6'b001010;
    localparam logic [OPC_BITS-1:0] OP_LOAD_MQX = 6'b001001;
    localparam logic [OPC_BITS-1:0] OP_STOR     = 6'b100001;
    localparam logic [OPC_BITS-1:0] OP_LOAD     = 6'b000001;
    localparam logic [OPC_BITS-1:0] OP_ADD      = 6'b000101;
    localparam logic [OPC_BITS-1:0] OP_SUB      = 6'b000110;
    localparam logic [OPC_BITS-1:0] OP_MUL      = 6'b001011;
    localparam logic [OPC_BITS-1:0] OP_DIV      = 6'b001100;

    // microcode addresses
    typedef enum logic [4:0] {
        U_DONE      = 5'd0,
        U_WRITE     = 5'd1,
        U_READ      = 5'd2,
        U_READ_LAT  = 5'd3,
        U_LDMQ      = 5'd4,
        U_LDMQX     = 5'd5,
        U_LDMQX_EX  = 5'd6,
        U_STOR      = 5'd7,
        U_LOAD      = 5'd8,
        U_LOAD_EX   = 5'd9,
        U_ADD       = 5'd10,
        U_ADD_EX    = 5'd11,
        U_SUB       = 5'd12,
        U_SUB_EX    = 5'd13,
        U_MUL       = 5'd14,
        U_MUL_INIT  = 5'd15,
        U_MUL_STEP  = 5'd16,
        U_DIV       = 5'd17,
        U_DIV_TEST  = 5'd18,
        U_DIV_INIT  = 5'd19,
        U_DIV_STEP  = 5'd20,
        U_DIV_ZERO  = 5'd21
    } t_uaddr;

    typedef enum logic [3:0] {
        DP_NOP      = 4'd0,
        DP_LAT_RD   = 4'd1,
        DP_AC_MQ    = 4'd2,
        DP_MQ_M     = 4'd3,
        DP_AC_M     = 4'd4,
        DP_ADD      = 4'd5,
        DP_SUB      = 4'd6,
        DP_MUL_INIT = 4'd7,
        DP_MUL_STEP = 4'd8,
        DP_DIV_INIT = 4'd9,
        DP_DIV_STEP = 4'd10,
        DP_SET_DZ   = 4'd11
    } t_dpop;

    typedef enum logic [1:0] {
        C_NEXT  = 2'd0,
        C_MZERO = 2'd1,
        C_LOOP  = 2'd2
    } t_cond;

    typedef enum logic {
        WS_DATA = 1'b0,
        WS_AC   = 1'b1
    } t_wsrc;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RUN   = 2'd2
    } t_state;

    typedef struct packed {
        logic   rd;
        logic   wr;
        t_wsrc  wsrc;
        t_dpop  dpop;
        logic   cnt_clr;
        logic   done;
        t_cond  cond;
        t_uaddr jmp;
        t_uaddr nxt;
    } t_uword;

    typedef struct packed {
        logic  accept;
        t_dpop dpop;
    } t_dpctl;

    typedef struct packed {
        logic  clr;
        logic  rd;
        logic  wr;
        t_wsrc wsrc;
    } t_memctl;

    // entry point of the microprogram for one item
    function automatic t_uaddr dispatch(input t_req req, input logic [OPC_BITS-1:0] op);
        t_uaddr a;
        a = U_DONE;
        case (req)
            REQ_WRITE: a = U_WRITE;
            REQ_READ:  a = U_READ;
            REQ_EXEC: begin
                case (op)
                    OP_LOAD_MQ:  a = U_LDMQ;
                    OP_LOAD_MQX: a = U_LDMQX;
                    OP_STOR:     a = U_STOR;
                    OP_LOAD:     a = U_LOAD;
                    OP_ADD:      a = U_ADD;
                    OP_SUB:      a = U_SUB;
                    OP_MUL:      a = U_MUL;
                    OP_DIV:      a = U_DIV;
                    default:     a = U_DONE;
                endcase
            end
            default: a = U_DONE;
        endcase
        return a;
    endfunction

    // control store
    function automatic t_uword ucode(input t_uaddr a);
        t_uword w;
        w = '{rd: 1'b0, wr: 1'b0, wsrc: WS_DATA, dpop: DP_NOP, cnt_clr: 1'b0,
              done: 1'b0, cond: C_NEXT, jmp: U_DONE, nxt: U_DONE};
        case (a)
            U_DONE:     w.done = 1'b1;
            U_WRITE:    w.wr = 1'b1;
            U_READ: begin
                w.rd  = 1'b1;
                w.nxt = U_READ_LAT;
            end
            U_READ_LAT: w.dpop = DP_LAT_RD;
            U_LDMQ:     w.dpop = DP_AC_MQ;
            U_LDMQX: begin
                w.rd  = 1'b1;
                w.nxt = U_LDMQX_EX;
            end
            U_LDMQX_EX: w.dpop = DP_MQ_M;
            U_STOR: begin
                w.wr   = 1'b1;
                w.wsrc = WS_AC;
            end
            U_LOAD: begin
                w.rd  = 1'b1;
                w.nxt = U_LOAD_EX;
            end
            U_LOAD_EX:  w.dpop = DP_AC_M;
            U_ADD: begin
                w.rd  = 1'b1;
                w.nxt = U_ADD_EX;
            end
            U_ADD_EX:   w.dpop = DP_ADD;
            U_SUB: begin
                w.rd  = 1'b1;
                w.nxt = U_SUB_EX;
            end
            U_SUB_EX:   w.dpop = DP_SUB;
            U_MUL: begin
                w.rd  = 1'b1;
                w.nxt = U_MUL_INIT;
            end
            U_MUL_INIT: begin
                w.dpop    = DP_MUL_INIT;
                w.cnt_clr = 1'b1;
                w.nxt     = U_MUL_STEP;
            end
            U_MUL_STEP: begin
                w.dpop = DP_MUL_STEP;
                w.cond = C_LOOP;
                w.jmp  = U_MUL_STEP;
            end
            U_DIV: begin
                w.rd  = 1'b1;
                w.nxt = U_DIV_TEST;
            end
            U_DIV_TEST: begin
                w.cond = C_MZERO;
                w.jmp  = U_DIV_ZERO;
                w.nxt  = U_DIV_INIT;
            end
            U_DIV_INIT: begin
                w.dpop    = DP_DIV_INIT;
                w.cnt_clr = 1'b1;
                w.nxt     = U_DIV_STEP;
            end
            U_DIV_STEP: begin
                w.dpop = DP_DIV_STEP;
                w.cond = C_LOOP;
                w.jmp  = U_DIV_STEP;
            end
            U_DIV_ZERO: w.dpop = DP_SET_DZ;
            default:    w.nxt = U_DONE;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

[rtl/ame_ram.sv]
// generic single-port ram with registered read
`default_nettype none

module ame_ram #(
    parameter int WIDTH = ame_pkg::WORD_BITS,
    parameter int DEPTH = ame_pkg::DEF_MEM_DEPTH
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

[rtl/ame_seq.sv]
// microcode sequencer: step counter, loop counter, memory clear sweep
`default_nettype none
`include "accumulator_machine_execute_unit_macros.svh"

module ame_seq #(
    parameter int MEM_DEPTH = ame_pkg::DEF_MEM_DEPTH
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [1:0]                    i_req_type,
    input  wire logic [ame_pkg::OPC_BITS-1:0]  i_opcode,
    input  wire logic                          i_m_zero,
    input  wire logic                          i_out_free,
    output logic                               o_out_load,
    output ame_pkg::t_dpctl                    o_dp,
    output ame_pkg::t_memctl                   o_mem,
    output logic [$clog2(MEM_DEPTH)-1:0]       o_clr_addr
);

    localparam int AW = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] CLR_LAST = AW'(MEM_DEPTH - 1);
    localparam logic [ame_pkg::CNT_BITS-1:0] CNT_LAST =
        ame_pkg::CNT_BITS'(ame_pkg::WORD_BITS - 1);

    ame_pkg::t_state r_state, n_state;
    ame_pkg::t_uaddr r_upc, n_upc;
    logic [ame_pkg::CNT_BITS-1:0] r_cnt, n_cnt;
    logic [AW-1:0] r_clr, n_clr;
    ame_pkg::t_uword uw;
    logic accept;

    assign uw = ame_pkg::ucode(r_upc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ame_pkg::ST_CLEAR;
            r_upc   <= ame_pkg::U_DONE;
            r_cnt   <= '0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
            r_cnt   <= n_cnt;
            r_clr   <= n_clr;
        end
    end

    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        n_cnt   = r_cnt;
        n_clr   = r_clr;

        o_in_ready  = (r_state == ame_pkg::ST_IDLE);
        accept      = i_in_valid && o_in_ready;
        o_out_load  = 1'b0;
        o_dp.accept = accept;
        o_dp.dpop   = ame_pkg::DP_NOP;
        o_mem.clr   = 1'b0;
        o_mem.rd    = 1'b0;
        o_mem.wr    = 1'b0;
        o_mem.wsrc  = uw.wsrc;
        o_clr_addr  = r_clr;

        case (r_state)
            ame_pkg::ST_CLEAR: begin
                // zero one memory word per cycle after reset
                o_mem.clr = 1'b1;
                n_clr     = r_clr + 1'b1;
                if (r_clr == CLR_LAST) begin
                    n_state = ame_pkg::ST_IDLE;
                end
            end
            ame_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = ame_pkg::ST_RUN;
                    n_upc   = ame_pkg::dispatch(ame_pkg::t_req'(i_req_type), i_opcode);
                end
            end
            ame_pkg::ST_RUN: begin
                o_dp.dpop = uw.dpop;
                o_mem.rd  = uw.rd;
                o_mem.wr  = uw.wr;
                n_cnt     = uw.cnt_clr ? '0 : r_cnt + 1'b1;
                if (uw.done) begin
                    // hold here until the output register can take the result
                    o_out_load = i_out_free;
                    if (i_out_free) begin
                        n_state = ame_pkg::ST_IDLE;
                    end
                end else begin
                    case (uw.cond)
                        ame_pkg::C_MZERO: n_upc = i_m_zero ? uw.jmp : uw.nxt;
                        ame_pkg::C_LOOP:  n_upc = (r_cnt != CNT_LAST) ? uw.jmp : uw.nxt;
                        default:          n_upc = uw.nxt;
                    endcase
                end
            end
            default: n_state = ame_pkg::ST_IDLE;
        endcase
    end

    `AME_ASSERT_NEXT(a_accept_starts_run, accept, r_state == ame_pkg::ST_RUN,
        "accepted item did not start the microprogram")
    `AME_ASSERT_NEXT(a_loop_repeats,
        (r_state == ame_pkg::ST_RUN) && !uw.done &&
        (uw.cond == ame_pkg::C_LOOP) && (r_cnt != CNT_LAST),
        r_upc == $past(r_upc), "iteration step left its loop early")
    `AME_ASSERT_NEXT(a_clear_ends,
        (r_state == ame_pkg::ST_CLEAR) && (r_clr == CLR_LAST),
        r_state == ame_pkg::ST_IDLE, "memory clear sweep did not finish")

endmodule

`default_nettype wire

[rtl/ame_dp.sv]
// datapath: ac, mq, operand register and the shift-add / shift-subtract unit
`default_nettype none
`include "accumulator_machine_execute_unit_macros.svh"

module ame_dp #(
    parameter int MEM_DEPTH = ame_pkg::DEF_MEM_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire ame_pkg::t_dpctl                i_ctl,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [ame_pkg::ADDR_BITS-1:0]  i_mem_addr,
    input  wire ame_pkg::t_word                 i_word_in,
    input  wire ame_pkg::t_word                 i_ram_q,
    output logic      [ame_pkg::ADDR_BITS-1:0]  o_addr,
    output logic                                o_addr_ok,
    output logic                                o_m_zero,
    output ame_pkg::t_word                      o_data,
    output ame_pkg::t_word                      o_ac,
    output ame_pkg::t_word                      o_mq,
    output ame_pkg::t_word                      o_read_word,
    output logic                                o_dz
);

    localparam int WB = ame_pkg::WORD_BITS;
    localparam logic [ame_pkg::ADDR_BITS:0] DEPTH_LIM = (ame_pkg::ADDR_BITS + 1)'(MEM_DEPTH);

    ame_pkg::t_word r_ac, n_ac;
    ame_pkg::t_word r_mq, n_mq;
    ame_pkg::t_word r_b, n_b;
    ame_pkg::t_word r_data, n_data;
    ame_pkg::t_word r_rdw, n_rdw;
    logic [ame_pkg::ADDR_BITS-1:0] r_addr, n_addr;
    logic r_dz, n_dz;

    ame_pkg::t_word m;
    logic [WB:0] mul_sum;
    logic [WB:0] div_shl;
    logic [WB:0] div_diff;
    logic div_ge;

    assign o_addr_ok = ({1'b0, r_addr} < DEPTH_LIM);
    // words beyond the memory read as zero
    assign m         = o_addr_ok ? i_ram_q : '0;
    assign o_m_zero  = (m == '0);

    assign mul_sum  = {1'b0, r_ac} + (r_mq[0] ? {1'b0, r_b} : '0);
    assign div_shl  = {r_ac, r_mq[WB-1]};
    assign div_ge   = (div_shl >= {1'b0, r_b});
    assign div_diff = div_shl - {1'b0, r_b};

    always_comb begin
        n_ac   = r_ac;
        n_mq   = r_mq;
        n_b    = r_b;
        n_addr = r_addr;
        n_data = r_data;
        n_rdw  = r_rdw;
        n_dz   = r_dz;
        if (i_ctl.accept) begin
            n_addr = (ame_pkg::t_req'(i_req_type) == ame_pkg::REQ_EXEC) ?
                     i_word_in[ame_pkg::ADDR_BITS-1:0] : i_mem_addr;
            n_data = i_word_in;
            n_rdw  = '0;
            n_dz   = 1'b0;
        end
        case (i_ctl.dpop)
            ame_pkg::DP_NOP:      ;
            ame_pkg::DP_LAT_RD:   n_rdw = m;
            ame_pkg::DP_AC_MQ:    n_ac = r_mq;
            ame_pkg::DP_MQ_M:     n_mq = m;
            ame_pkg::DP_AC_M:     n_ac = m;
            ame_pkg::DP_ADD:      n_ac = r_ac + m;
            ame_pkg::DP_SUB:      n_ac = m - r_ac;
            ame_pkg::DP_MUL_INIT: begin
                n_b  = m;
                n_ac = '0;
            end
            ame_pkg::DP_MUL_STEP: begin
                // {ac,mq} shifts right one bit per step, multiplier bits leave mq
                n_ac = mul_sum[WB:1];
                n_mq = {mul_sum[0], r_mq[WB-1:1]};
            end
            ame_pkg::DP_DIV_INIT: begin
                n_b  = m;
                n_mq = r_ac;
                n_ac = '0;
            end
            ame_pkg::DP_DIV_STEP: begin
                // restoring divide: partial remainder in ac, quotient bits enter mq
                n_ac = div_ge ? div_diff[WB-1:0] : div_shl[WB-1:0];
                n_mq = {r_mq[WB-2:0], div_ge};
            end
            ame_pkg::DP_SET_DZ:   n_dz = 1'b1;
            default:              ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ac <= '0;
            r_mq <= '0;
        end else begin
            r_ac <= n_ac;
            r_mq <= n_mq;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b    <= n_b;
        r_addr <= n_addr;
        r_data <= n_data;
        r_rdw  <= n_rdw;
        r_dz   <= n_dz;
    end

    assign o_addr      = r_addr;
    assign o_data      = r_data;
    assign o_ac        = r_ac;
    assign o_mq        = r_mq;
    assign o_read_word = r_rdw;
    assign o_dz        = r_dz;

    `AME_ASSERT_IMP(a_div_nonzero, i_ctl.dpop == ame_pkg::DP_DIV_INIT, !o_m_zero,
        "divide started with a zero divisor")
    `AME_ASSERT_NEXT(a_rem_below_div, i_ctl.dpop == ame_pkg::DP_DIV_STEP, r_ac < r_b,
        "partial remainder not below divisor")

endmodule

`default_nettype wire

[rtl/accumulator_machine_execute_unit.sv]
// top level of the accumulator machine execute unit
`default_nettype none

// Microcoded 16-bit accumulator machine with a MEM_DEPTH-word memory, AC and MQ.
// Each transfer in is a memory write, a memory read or one instruction word; each
// produces one transfer out with AC, MQ, the word read and the divide-by-zero flag.
// After reset the memory is swept to zero, one word per cycle, so the input is not
// ready until the sweep has finished. Unknown opcodes and the unused request type
// still produce a transfer out; DIV with a zero divisor skips the divide loop and
// sets the divide-by-zero flag. MUL and DIV go one bit per cycle through a 17-bit
// adder (MUL) or subtractor (DIV); every operand fetch costs one registered memory
// read. The output register lets the next item be accepted while a result still
// waits to be taken.
module accumulator_machine_execute_unit #(
    parameter int MEM_DEPTH = ame_pkg::DEF_MEM_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [1:0]                     i_req_type,
    input  wire logic [ame_pkg::ADDR_BITS-1:0]  i_mem_addr,
    input  wire logic [ame_pkg::WORD_BITS-1:0]  i_word_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output logic      [ame_pkg::WORD_BITS-1:0]  o_acc_value,
    output logic      [ame_pkg::WORD_BITS-1:0]  o_mq_value,
    output logic      [ame_pkg::WORD_BITS-1:0]  o_read_word,
    output logic                                o_divide_by_zero
);

    localparam int AW = $clog2(MEM_DEPTH);

    ame_pkg::t_dpctl  dp_ctl;
    ame_pkg::t_memctl mem_ctl;
    logic [AW-1:0] clr_addr;
    logic out_load;
    logic out_free;

    logic [ame_pkg::ADDR_BITS-1:0] dp_addr;
    logic addr_ok;
    logic m_zero;
    ame_pkg::t_word dp_data;
    ame_pkg::t_word dp_ac;
    ame_pkg::t_word dp_mq;
    ame_pkg::t_word dp_rdw;
    logic dp_dz;

    logic ram_we;
    logic [AW-1:0] ram_addr;
    ame_pkg::t_word ram_wdata;
    ame_pkg::t_word ram_q;

    logic r_out_valid;
    ame_pkg::t_word r_acc, r_mq, r_rdw;
    logic r_dz;

    assign out_free = !r_out_valid || i_out_ready;

    ame_seq #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_req_type (i_req_type),
        .i_opcode   (i_word_in[ame_pkg::WORD_BITS-1:ame_pkg::ADDR_BITS]),
        .i_m_zero   (m_zero),
        .i_out_free (out_free),
        .o_out_load (out_load),
        .o_dp       (dp_ctl),
        .o_mem      (mem_ctl),
        .o_clr_addr (clr_addr)
    );

    ame_dp #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (dp_ctl),
        .i_req_type  (i_req_type),
        .i_mem_addr  (i_mem_addr),
        .i_word_in   (i_word_in),
        .i_ram_q     (ram_q),
        .o_addr      (dp_addr),
        .o_addr_ok   (addr_ok),
        .o_m_zero    (m_zero),
        .o_data      (dp_data),
        .o_ac        (dp_ac),
        .o_mq        (dp_mq),
        .o_read_word (dp_rdw),
        .o_dz        (dp_dz)
    );

    // writes beyond the memory are dropped
    assign ram_we    = mem_ctl.clr || (mem_ctl.wr && addr_ok);
    assign ram_addr  = mem_ctl.clr ? clr_addr : dp_addr[AW-1:0];
    assign ram_wdata = mem_ctl.clr ? '0 :
                       ((mem_ctl.wsrc == ame_pkg::WS_AC) ? dp_ac : dp_data);

    ame_ram #(
        .WIDTH (ame_pkg::WORD_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (mem_ctl.rd),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_acc <= dp_ac;
            r_mq  <= dp_mq;
            r_rdw <= dp_rdw;
            r_dz  <= dp_dz;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_acc_value      = r_acc;
    assign o_mq_value       = r_mq;
    assign o_read_word      = r_rdw;
    assign o_divide_by_zero = r_dz;

endmodule

`default_nettype wire

[verif/tb_accumulator_machine_execute_unit.sv]
// testbench for the accumulator machine execute unit: directed and random items
`default_nettype none

module tb_accumulator_machine_execute_unit;

    localparam logic [ame_pkg::OPC_BITS-1:0] OP_UNDEF_ONES = 6'b111111;
    localparam logic [ame_pkg::OPC_BITS-1:0] OP_UNDEF_ZERO = 6'b000000;
    localparam int DEPTH = ame_pkg::DEF_MEM_DEPTH;

    typedef struct packed {
        ame_pkg::t_word acc;
        ame_pkg::t_word mq;
        ame_pkg::t_word rd;
        logic           dz;
    } t_exec_result;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic [1:0]                    req_type  = '0;
    logic [ame_pkg::ADDR_BITS-1:0] mem_addr  = '0;
    ame_pkg::t_word                word_in   = '0;
    logic                          out_ready = 1'b0;
    logic                          out_hold  = 1'b0;

    logic                          in_ready;
    logic                          out_valid;
    ame_pkg::t_word                acc_value;
    ame_pkg::t_word                mq_value;
    ame_pkg::t_word                read_word;
    logic                          divide_by_zero;

    // machine state as the block should hold it
    ame_pkg::t_word                shadow_mem [DEPTH];
    ame_pkg::t_word                shadow_ac;
    ame_pkg::t_word                shadow_mq;

    t_exec_result                  outcome_q [$];
    int                            fail_count    = 0;
    int                            send_idle_pct = 0;
    int                            recv_idle_pct = 0;
    int                            hold_cycles   = 0;
    event                          stall_kick;

    accumulator_machine_execute_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_mem_addr       (mem_addr),
        .i_word_in        (word_in),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_acc_value      (acc_value),
        .o_mq_value       (mq_value),
        .o_read_word      (read_word),
        .o_divide_by_zero (divide_by_zero)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    initial begin
        #6_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // one item through the machine: update the shadow state, return what comes out
    function automatic t_exec_result machine_step(input ame_pkg::t_req rt,
                                                  input logic [ame_pkg::ADDR_BITS-1:0] a,
                                                  input ame_pkg::t_word w);
        t_exec_result r;
        logic [ame_pkg::OPC_BITS-1:0] op;
        logic [ame_pkg::ADDR_BITS-1:0] x;
        ame_pkg::t_word m;
        ame_pkg::t_word ac;
        logic [2*ame_pkg::WORD_BITS-1:0] prod;
        r  = '0;
        op = w[ame_pkg::WORD_BITS-1:ame_pkg::ADDR_BITS];
        x  = w[ame_pkg::ADDR_BITS-1:0];
        m  = shadow_mem[x];
        ac = shadow_ac;
        case (rt)
            ame_pkg::REQ_WRITE: shadow_mem[a] = w;
            ame_pkg::REQ_READ:  r.rd = shadow_mem[a];
            ame_pkg::REQ_EXEC: begin
                case (op)
                    ame_pkg::OP_LOAD_MQ:  shadow_ac = shadow_mq;
                    ame_pkg::OP_LOAD_MQX: shadow_mq = m;
                    ame_pkg::OP_STOR:     shadow_mem[x] = ac;
                    ame_pkg::OP_LOAD:     shadow_ac = m;
                    ame_pkg::OP_ADD:      shadow_ac = ac + m;
                    ame_pkg::OP_SUB:      shadow_ac = m - ac;
                    ame_pkg::OP_MUL: begin
                        prod = {{ame_pkg::WORD_BITS{1'b0}}, m} *
                               {{ame_pkg::WORD_BITS{1'b0}}, shadow_mq};
                        shadow_ac = prod[2*ame_pkg::WORD_BITS-1:ame_pkg::WORD_BITS];
                        shadow_mq = prod[ame_pkg::WORD_BITS-1:0];
                    end
                    ame_pkg::OP_DIV: begin
                        if (m == '0) begin
                            r.dz = 1'b1;
                        end else begin
                            shadow_mq = ac / m;
                            shadow_ac = ac % m;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.acc = shadow_ac;
        r.mq  = shadow_mq;
        return r;
    endfunction

    function automatic ame_pkg::t_word instr(input logic [ame_pkg::OPC_BITS-1:0] op,
                                             input logic [ame_pkg::ADDR_BITS-1:0] x);
        return {op, x};
    endfunction

    // mostly a small pool at both ends of memory so that words get reused
    function automatic logic [ame_pkg::ADDR_BITS-1:0] pick_addr();
        logic [ame_pkg::ADDR_BITS-1:0] a;
        if ($urandom_range(3) == 0) begin
            a = ame_pkg::ADDR_BITS'($urandom);
        end else begin
            a = {{(ame_pkg::ADDR_BITS-4){$urandom_range(1) == 1}}, 4'($urandom)};
        end
        return a;
    endfunction

    function automatic ame_pkg::t_word pick_data();
        ame_pkg::t_word d;
        case ($urandom_range(9))
            0:       d = '0;
            1:       d = '1;
            2, 3:    d = ame_pkg::t_word'($urandom_range(15));
            default: d = ame_pkg::t_word'($urandom);
        endcase
        return d;
    endfunction

    function automatic logic [ame_pkg::OPC_BITS-1:0] pick_opcode();
        logic [ame_pkg::OPC_BITS-1:0] op;
        if ($urandom_range(9) == 0) begin
            op = ame_pkg::OPC_BITS'($urandom);
        end else begin
            case ($urandom_range(7))
                0:       op = ame_pkg::OP_LOAD_MQ;
                1:       op = ame_pkg::OP_LOAD_MQX;
                2:       op = ame_pkg::OP_STOR;
                3:       op = ame_pkg::OP_LOAD;
                4:       op = ame_pkg::OP_ADD;
                5:       op = ame_pkg::OP_SUB;
                6:       op = ame_pkg::OP_MUL;
                default: op = ame_pkg::OP_DIV;
            endcase
        end
        return op;
    endfunction

    task automatic send_item(input ame_pkg::t_req rt,
                             input logic [ame_pkg::ADDR_BITS-1:0] a,
                             input ame_pkg::t_word w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= rt;
        mem_addr <= a;
        word_in  <= w;
        @(posedge clk);
        while (in_ready !== 1'b1) @(posedge clk);
        outcome_q.push_back(machine_step(rt, a, w));
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outcome_q.size() != 0);
    endtask

    task automatic test_memory_extremes();
        send_item(ame_pkg::REQ_WRITE, '0, 16'hFFFF);
        send_item(ame_pkg::REQ_WRITE, '1, 16'h8001);
        send_item(ame_pkg::REQ_WRITE, 10'h155, 16'hAAAA);
        send_item(ame_pkg::REQ_WRITE, 10'h2AA, 16'h5555);
        send_item(ame_pkg::REQ_READ, '0, 16'hFFFF);
        send_item(ame_pkg::REQ_READ, '1, '0);
        send_item(ame_pkg::REQ_READ, 10'h155, 16'h5555);
        send_item(ame_pkg::REQ_READ, 10'h2AA, 16'hAAAA);
        // word never written reads back as cleared
        send_item(ame_pkg::REQ_READ, 10'h200, '0);
        send_item(ame_pkg::REQ_NONE, '1, 16'hFFFF);
    endtask

    task automatic test_each_opcode();
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_LOAD, '0));
        // wraps past 2^16
        send_item(ame_pkg::REQ_EXEC, '1, instr(ame_pkg::OP_ADD, '1));
        // memory minus ac, goes negative
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_SUB, 10'h2AA));
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_LOAD_MQX, '0));
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_LOAD, '0));
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_MUL, '0));
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_STOR, 10'h007));
        send_item(ame_pkg::REQ_READ, 10'h007, '0);
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_LOAD_MQ, '0));
        // zero divisor leaves ac and mq alone
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_DIV, 10'h200));
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_LOAD, 10'h155));
        send_item(ame_pkg::REQ_EXEC, '0, instr(ame_pkg::OP_DIV, '1));
        send_item(ame_pkg::REQ_EXEC, '1, instr(OP_UNDEF_ONES, '1));
        send_item(ame_pkg::REQ_EXEC, '0, instr(OP_UNDEF_ZERO, '0));
    endtask

    task automatic test_random_traffic(input int count);
        int kind;
        ame_pkg::t_req rt;
        logic [ame_pkg::ADDR_BITS-1:0] a;
        ame_pkg::t_word w;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(99);
            a    = pick_addr();
            if (kind < 18) begin
                rt = ame_pkg::REQ_WRITE;
                w  = pick_data();
            end else if (kind < 32) begin
                rt = ame_pkg::REQ_READ;
                w  = ame_pkg::t_word'($urandom);
            end else if (kind < 36) begin
                rt = ame_pkg::REQ_NONE;
                w  = ame_pkg::t_word'($urandom);
            end else begin
                rt = ame_pkg::REQ_EXEC;
                w  = instr(pick_opcode(), pick_addr());
            end
            send_item(rt, a, w);
        end
    endtask

    // sender stops until every result is back, then carries on
    task automatic test_drain_pause();
        test_random_traffic(30);
        wait_for_results();
        test_random_traffic(30);
    endtask

    // receiver blocked long enough that the block stops taking input
    task automatic test_output_backpressure();
        hold_cycles = 400;
        -> stall_kick;
        test_random_traffic(40);
        wait_for_results();
    endtask

    initial begin
        forever begin
            @(stall_kick);
            out_hold <= 1'b1;
            repeat (hold_cycles) @(posedge clk);
            out_hold <= 1'b0;
        end
    end

    always @(posedge clk) begin
        out_ready <= !out_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk) begin : check_outcome
        t_exec_result want;
        t_exec_result got;
        if (rst_n && out_valid === 1'b1 && out_ready) begin
            got = '{acc: acc_value, mq: mq_value, rd: read_word, dz: divide_by_zero};
            if (outcome_q.size() == 0) begin
                if (fail_count < 10) begin
                    $display("unexpected transfer out: ac=%h mq=%h rd=%h dz=%b",
                             got.acc, got.mq, got.rd, got.dz);
                end
                fail_count++;
            end else begin
                want = outcome_q.pop_front();
                if (got.acc !== want.acc || got.mq !== want.mq ||
                    got.rd !== want.rd || got.dz !== want.dz) begin
                    if (fail_count < 10) begin
                        $display({"mismatch: exp ac=%h mq=%h rd=%h dz=%b ",
                                  "got ac=%h mq=%h rd=%h dz=%b"},
                                 want.acc, want.mq, want.rd, want.dz,
                                 got.acc, got.mq, got.rd, got.dz);
                    end
                    fail_count++;
                end
            end
        end
    end

    initial begin
        for (int k = 0; k < DEPTH; k++) shadow_mem[k] = '0;
        shadow_ac = '0;
        shadow_mq = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_memory_extremes();
        test_each_opcode();

        send_idle_pct = 30;
        recv_idle_pct <= 46;
        test_random_traffic(590);
        test_drain_pause();

        send_idle_pct = 46;
        recv_idle_pct <= 30;
        test_random_traffic(590);
        test_output_backpressure();

        send_idle_pct = 0;
        recv_idle_pct <= 0;
        test_random_traffic(590);

        wait_for_results();
        repeat (30) @(posedge clk);
        if (fail_count == 0 && outcome_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
